FILE: src/mnpm_pkg.sv
// Shared constants, codes and types of the MIDI note pair matcher.
package mnpm_pkg;

    localparam int PENDING_DEPTH = 32;
    localparam int INDEX_BITS    = 16;
    localparam int COUNT_W       = $clog2(PENDING_DEPTH + 1);
    localparam int PTR_W         = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;

    localparam int DELTA_W   = 28;
    localparam int KIND_W    = 2;
    localparam int PITCH_W   = 7;
    localparam int CHAN_W    = 4;
    localparam int VEL_W     = 7;
    localparam int TIME_W    = 32;
    localparam int OUT_IDX_W = 16;

    typedef logic [KIND_W-1:0]     kind_t;
    typedef logic [PITCH_W-1:0]    pitch_t;
    typedef logic [CHAN_W-1:0]     chan_t;
    typedef logic [INDEX_BITS-1:0] idx_t;
    typedef logic [COUNT_W-1:0]    count_t;
    typedef logic [PTR_W-1:0]      ptr_t;

    localparam kind_t KIND_OTHER = 2'd0;
    localparam kind_t KIND_ON    = 2'd1;
    localparam kind_t KIND_OFF   = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_OUT  = 3'b100
    } state_t;

    // Sequencer to pending table
    typedef struct packed {
        logic   append;
        logic   remove;
        count_t scan;
        pitch_t pitch;
        chan_t  chan;
        idx_t   start_idx;
    } tbl_ctrl_t;

    // Pending table to sequencer
    typedef struct packed {
        logic hit;
        logic at_end;
        logic full;
        idx_t hit_idx;
    } tbl_stat_t;

endpackage

FILE: src/mnpm_if.sv
// Request and result channel interfaces of the MIDI note pair matcher.
interface mnpm_req_if;
    logic                            valid;
    logic                            ready;
    logic [mnpm_pkg::DELTA_W-1:0]    delta_ticks;
    logic [mnpm_pkg::KIND_W-1:0]     req_type;
    logic [mnpm_pkg::PITCH_W-1:0]    pitch;
    logic [mnpm_pkg::CHAN_W-1:0]     channel;
    logic [mnpm_pkg::VEL_W-1:0]      velocity;

    modport source (
        output valid, delta_ticks, req_type, pitch, channel, velocity,
        input  ready
    );
    modport sink (
        input  valid, delta_ticks, req_type, pitch, channel, velocity,
        output ready
    );
endinterface

interface mnpm_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [mnpm_pkg::TIME_W-1:0]      absolute_time;
    logic                             pair_found;
    logic [mnpm_pkg::OUT_IDX_W-1:0]   on_index;
    logic [mnpm_pkg::OUT_IDX_W-1:0]   off_index;
    logic                             table_full_drop;

    modport source (
        output valid, absolute_time, pair_found, on_index, off_index, table_full_drop,
        input  ready
    );
    modport sink (
        input  valid, absolute_time, pair_found, on_index, off_index, table_full_drop,
        output ready
    );
endinterface

FILE: src/mnpm_table.sv
// Ordered table of pending note-ons with one scan read port and compaction on removal.
module mnpm_table (
    input  logic                clk,
    input  logic                rst_n,
    input  mnpm_pkg::tbl_ctrl_t ctrl,
    output mnpm_pkg::tbl_stat_t stat
);

    localparam int DEPTH = mnpm_pkg::PENDING_DEPTH;

    mnpm_pkg::pitch_t pitch_reg [DEPTH];
    mnpm_pkg::chan_t  chan_reg  [DEPTH];
    mnpm_pkg::idx_t   idx_reg   [DEPTH];
    mnpm_pkg::pitch_t pitch_next [DEPTH];
    mnpm_pkg::chan_t  chan_next  [DEPTH];
    mnpm_pkg::idx_t   idx_next   [DEPTH];

    mnpm_pkg::count_t count_reg;
    mnpm_pkg::count_t count_next;
    mnpm_pkg::ptr_t   ptr;
    mnpm_pkg::ptr_t   tail;

    assign ptr  = ctrl.scan[mnpm_pkg::PTR_W-1:0];
    assign tail = count_reg[mnpm_pkg::PTR_W-1:0];

    // Close the gap left by a removed entry, or write a new entry at the tail
    always_comb
    begin
        for (int j = 0; j < DEPTH; j++)
        begin
            pitch_next[j] = pitch_reg[j];
            chan_next[j]  = chan_reg[j];
            idx_next[j]   = idx_reg[j];
        end
        if (ctrl.remove)
        begin
            for (int j = 0; j < DEPTH - 1; j++)
            begin
                if (mnpm_pkg::PTR_W'(j) >= ptr)
                begin
                    pitch_next[j] = pitch_reg[j + 1];
                    chan_next[j]  = chan_reg[j + 1];
                    idx_next[j]   = idx_reg[j + 1];
                end
            end
        end
        else if (ctrl.append)
        begin
            pitch_next[tail] = ctrl.pitch;
            chan_next[tail]  = ctrl.chan;
            idx_next[tail]   = ctrl.start_idx;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.remove)
        begin
            count_next = count_reg - 1'b1;
        end
        else if (ctrl.append)
        begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < DEPTH; j++)
        begin
            pitch_reg[j] <= pitch_next[j];
            chan_reg[j]  <= chan_next[j];
            idx_reg[j]   <= idx_next[j];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign stat.at_end  = (ctrl.scan >= count_reg);
    assign stat.full    = (count_reg == mnpm_pkg::COUNT_W'(DEPTH));
    assign stat.hit     = !stat.at_end && (pitch_reg[ptr] == ctrl.pitch)
                          && (chan_reg[ptr] == ctrl.chan);
    assign stat.hit_idx = idx_reg[ptr];

endmodule

FILE: src/midi_note_pair_matcher.sv
// Top level: pairs MIDI note-on events with their note-offs, one event at a time.
// One event is taken per transfer on req, and exactly one result leaves on rsp. The block
// takes an event only when idle (req.ready high) and then holds req.ready low until the
// result has been transferred. Other events and note-ons go from ST_EXEC straight to ST_OUT;
// a note-off walks the pending table oldest first in ST_EXEC, one entry a cycle through the
// table's single read port, until a match or the end of the table. Absolute time saturates
// at 2^32-1 and the event index wraps. Reset empties the table at once; no clearing pass is
// needed.
module midi_note_pair_matcher (
    input logic        clk,
    input logic        rst_n,
    mnpm_req_if.sink   req,
    mnpm_rsp_if.source rsp
);

    mnpm_pkg::state_t state_reg, state_next;
    logic [mnpm_pkg::TIME_W-1:0] time_reg, time_next;
    mnpm_pkg::idx_t   evt_cnt_reg, evt_cnt_next;
    mnpm_pkg::idx_t   cur_idx_reg, cur_idx_next;
    mnpm_pkg::idx_t   on_idx_reg, on_idx_next;
    mnpm_pkg::pitch_t pitch_reg, pitch_next;
    mnpm_pkg::chan_t  chan_reg, chan_next;
    mnpm_pkg::count_t scan_reg, scan_next;
    logic is_on_reg, is_on_next;
    logic is_off_reg, is_off_next;
    logic found_reg, found_next;
    logic drop_reg, drop_next;

    logic [mnpm_pkg::TIME_W:0] time_sum;
    logic accept;
    logic req_is_on;
    logic req_is_off;

    mnpm_pkg::tbl_ctrl_t tbl_ctrl;
    mnpm_pkg::tbl_stat_t tbl_stat;

    mnpm_table u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (tbl_ctrl),
        .stat  (tbl_stat)
    );

    assign req.ready = (state_reg == mnpm_pkg::ST_IDLE);
    assign accept    = req.valid && req.ready;

    assign time_sum   = {1'b0, time_reg} + (mnpm_pkg::TIME_W + 1)'(req.delta_ticks);
    assign req_is_on  = (req.req_type == mnpm_pkg::KIND_ON) && (req.velocity != '0);
    assign req_is_off = (req.req_type == mnpm_pkg::KIND_OFF)
                        || ((req.req_type == mnpm_pkg::KIND_ON) && (req.velocity == '0));

    always_comb
    begin
        state_next   = state_reg;
        time_next    = time_reg;
        evt_cnt_next = evt_cnt_reg;
        cur_idx_next = cur_idx_reg;
        on_idx_next  = on_idx_reg;
        pitch_next   = pitch_reg;
        chan_next    = chan_reg;
        scan_next    = scan_reg;
        is_on_next   = is_on_reg;
        is_off_next  = is_off_reg;
        found_next   = found_reg;
        drop_next    = drop_reg;

        tbl_ctrl.append    = 1'b0;
        tbl_ctrl.remove    = 1'b0;
        tbl_ctrl.scan      = scan_reg;
        tbl_ctrl.pitch     = pitch_reg;
        tbl_ctrl.chan      = chan_reg;
        tbl_ctrl.start_idx = cur_idx_reg;

        unique case (state_reg)
            mnpm_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    // saturate the running time at all ones
                    time_next    = time_sum[mnpm_pkg::TIME_W] ? '1
                                   : time_sum[mnpm_pkg::TIME_W-1:0];
                    cur_idx_next = evt_cnt_reg;
                    evt_cnt_next = evt_cnt_reg + 1'b1;
                    pitch_next   = req.pitch;
                    chan_next    = req.channel;
                    is_on_next   = req_is_on;
                    is_off_next  = req_is_off;
                    scan_next    = '0;
                    found_next   = 1'b0;
                    drop_next    = 1'b0;
                    on_idx_next  = '0;
                    state_next   = mnpm_pkg::ST_EXEC;
                end
            end
            mnpm_pkg::ST_EXEC:
            begin
                priority if (is_on_reg)
                begin
                    if (tbl_stat.full)
                    begin
                        drop_next = 1'b1;
                    end
                    else
                    begin
                        tbl_ctrl.append = 1'b1;
                    end
                    state_next = mnpm_pkg::ST_OUT;
                end
                else if (is_off_reg)
                begin
                    // advance one entry a cycle until a match or the end of the table
                    priority if (tbl_stat.at_end)
                    begin
                        state_next = mnpm_pkg::ST_OUT;
                    end
                    else if (tbl_stat.hit)
                    begin
                        tbl_ctrl.remove = 1'b1;
                        found_next      = 1'b1;
                        on_idx_next     = tbl_stat.hit_idx;
                        state_next      = mnpm_pkg::ST_OUT;
                    end
                    else
                    begin
                        scan_next = scan_reg + 1'b1;
                    end
                end
                else
                begin
                    state_next = mnpm_pkg::ST_OUT;
                end
            end
            mnpm_pkg::ST_OUT:
            begin
                if (rsp.ready)
                begin
                    state_next = mnpm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mnpm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= mnpm_pkg::ST_IDLE;
            time_reg    <= '0;
            evt_cnt_reg <= '0;
            found_reg   <= 1'b0;
            drop_reg    <= 1'b0;
            is_on_reg   <= 1'b0;
            is_off_reg  <= 1'b0;
            scan_reg    <= '0;
            on_idx_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            time_reg    <= time_next;
            evt_cnt_reg <= evt_cnt_next;
            found_reg   <= found_next;
            drop_reg    <= drop_next;
            is_on_reg   <= is_on_next;
            is_off_reg  <= is_off_next;
            scan_reg    <= scan_next;
            on_idx_reg  <= on_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_idx_reg <= cur_idx_next;
        pitch_reg   <= pitch_next;
        chan_reg    <= chan_next;
    end

    assign rsp.valid           = (state_reg == mnpm_pkg::ST_OUT);
    assign rsp.absolute_time   = time_reg;
    assign rsp.pair_found      = found_reg;
    assign rsp.on_index        = mnpm_pkg::OUT_IDX_W'(on_idx_reg);
    assign rsp.off_index       = found_reg ? mnpm_pkg::OUT_IDX_W'(cur_idx_reg) : '0;
    assign rsp.table_full_drop = drop_reg;

endmodule

FILE: src/mnpm_checker.sv
// Port-level checks of the MIDI note pair matcher, bound to the top level.
module mnpm_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             req_valid,
    input logic                             req_ready,
    input logic                             rsp_valid,
    input logic                             rsp_ready,
    input logic [mnpm_pkg::TIME_W-1:0]      absolute_time,
    input logic                             pair_found,
    input logic [mnpm_pkg::OUT_IDX_W-1:0]   on_index,
    input logic [mnpm_pkg::OUT_IDX_W-1:0]   off_index,
    input logic                             table_full_drop
);

    // one event in flight: no new transfer while a result waits
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !req_ready)
    else $error("request taken while a result is pending");

    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
    else $error("ready stayed high after an event transfer");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_ready) |=> !rsp_valid)
    else $error("result repeated after its transfer");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !pair_found) |-> (on_index == '0 && off_index == '0))
    else $error("indices set on a result without a pair");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(absolute_time)
                                       && $stable(table_full_drop)))
    else $error("stalled result changed");

endmodule

bind midi_note_pair_matcher mnpm_checker u_mnpm_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .absolute_time   (rsp.absolute_time),
    .pair_found      (rsp.pair_found),
    .on_index        (rsp.on_index),
    .off_index       (rsp.off_index),
    .table_full_drop (rsp.table_full_drop)
);
